/* rtl/scba_pkg.sv */
// Shared types, constants and helpers of the size class block allocator.
`default_nettype none
package scba_pkg;

  localparam int POOLS       = 4;
  localparam int BLOCKS      = 256;
  localparam int PW          = $clog2(POOLS);
  localparam int IW          = $clog2(BLOCKS);
  localparam int CW          = IW + 1;
  localparam int SW          = 16;
  localparam int QDEPTH      = 2;

  // Register indexes
  localparam logic [2:0] REG_SIZE_0  = 3'd0;
  localparam logic [2:0] REG_SIZE_1  = 3'd1;
  localparam logic [2:0] REG_SIZE_2  = 3'd2;
  localparam logic [2:0] REG_SIZE_3  = 3'd3;
  localparam logic [2:0] REG_COUNT_0 = 3'd4;
  localparam logic [2:0] REG_COUNT_1 = 3'd5;
  localparam logic [2:0] REG_COUNT_2 = 3'd6;
  localparam logic [2:0] REG_COUNT_3 = 3'd7;

  // Operation and status codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_DOUBLE  = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_CLEAR
  } bk_state_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic              op;
    logic [PW-1:0]     pool;
    logic [IW-1:0]     idx;
    logic [POOLS-1:0]  fits;
    logic              bad;
  } req_t;

  // Block count write, reinitializes one pool
  typedef struct packed {
    logic          en;
    logic [PW-1:0] pool;
    logic [CW-1:0] eff;
  } cnt_wr_t;

  // Block count limited to the pool depth
  function automatic logic [CW-1:0] eff_count(input logic [8:0] c);
    logic [CW-1:0] r;
    if ({1'b0, c} > 10'(BLOCKS)) r = CW'(BLOCKS);
    else r = CW'(c);
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/scba_front.sv */
// Request intake: classifies each word and buffers it in a short queue.
`default_nettype none
module scba_front import scba_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                operation,
  input  wire logic [SW-1:0]       request_size,
  input  wire logic [PW-1:0]       pool_id,
  input  wire logic [IW-1:0]       block_index,
  input  wire logic [SW-1:0]       pool_size [POOLS],
  input  wire logic [8:0]          block_count [POOLS],
  input  wire logic                hold,
  output logic                     q_valid,
  output req_t                     q_head,
  input  wire logic                q_pop
);

  req_t       q_mem [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  req_t       cls;

  // Classify: size fit per pool and handle check for frees
  always_comb begin
    cls.op   = operation;
    cls.pool = pool_id;
    cls.idx  = block_index;
    for (int p = 0; p < POOLS; p++) begin
      cls.fits[p] = (request_size <= pool_size[p]);
    end
    cls.bad = ({1'b0, block_index} >= eff_count(block_count[pool_id]));
  end

  assign in_stall = (fill == 2'(QDEPTH)) || hold;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_head   = q_mem[rd_ptr];

  // Store classified word
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cls;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/scba_back.sv */
// Executes requests against free queues and allocated bitmap, clears pools.
`default_nettype none
module scba_back import scba_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [CW-1:0]       eff [POOLS],
  input  wire cnt_wr_t             cnt_wr,
  input  wire logic                q_valid,
  input  wire req_t                q_head,
  output logic                     q_pop,
  output logic                     hold,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [PW-1:0]            granted_pool,
  output logic [IW-1:0]            granted_index
);

  localparam int AW = PW + IW;

  // Free queue store and allocated bitmap
  logic [IW-1:0] qmem [POOLS*BLOCKS];
  logic          bmem [POOLS*BLOCKS];
  logic [IW-1:0] q_rdata;
  logic          b_rdata;

  logic [IW-1:0] head  [POOLS];
  logic [IW-1:0] tail  [POOLS];
  logic [CW-1:0] qfill [POOLS];
  logic [CW-1:0] wcnt  [POOLS];
  logic [POOLS-1:0] pend;

  bk_state_t state, state_next;
  req_t      cur;
  logic [PW-1:0] sel, sel_next;
  logic          found, found_next;
  logic          wrt, wrt_next;
  logic [IW-1:0] hsave, hsave_next;
  logic [PW-1:0] clr_pool, clr_pool_next;
  logic [IW-1:0] clr_cnt;

  logic          rd_en;
  logic [AW-1:0] q_raddr, b_raddr;
  logic          qw_en, bw_en, bw_data;
  logic [AW-1:0] qw_addr, bw_addr;
  logic [IW-1:0] qw_data;
  logic          out_free, do_exec;
  logic [IW-1:0] off, blk;
  logic [PW-1:0] low_pend;

  assign out_free = !out_valid || !out_stall;
  assign hold     = (pend != '0) || (state == BK_CLEAR);

  // Pick first fitting nonempty pool and lowest pending clear
  always_comb begin
    sel_next   = '0;
    found_next = 1'b0;
    low_pend   = '0;
    for (int p = POOLS - 1; p >= 0; p--) begin
      if (q_head.fits[p] && qfill[p] != '0) begin
        sel_next   = PW'(p);
        found_next = 1'b1;
      end
      if (pend[p]) low_pend = PW'(p);
    end
    hsave_next = head[sel_next];
    off        = head[sel_next] - eff[sel_next][IW-1:0];
    wrt_next   = ({1'b0, off} < wcnt[sel_next]);
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    do_exec       = 1'b0;
    clr_pool_next = clr_pool;
    q_raddr       = {sel_next, head[sel_next]};
    b_raddr       = {q_head.pool, q_head.idx};
    unique case (state)
      BK_IDLE: begin
        if (pend != '0) begin
          clr_pool_next = low_pend;
          state_next    = BK_CLEAR;
        end else if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          do_exec    = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        if (clr_cnt == '1) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign blk = wrt ? q_rdata : hsave;

  // Memory writes for the executing request or clearing pass
  always_comb begin
    qw_en   = 1'b0;
    qw_addr = {cur.pool, tail[cur.pool]};
    qw_data = cur.idx;
    bw_en   = 1'b0;
    bw_addr = {cur.pool, cur.idx};
    bw_data = 1'b0;
    if (state == BK_CLEAR) begin
      bw_en   = 1'b1;
      bw_addr = {clr_pool, clr_cnt};
    end else if (do_exec) begin
      if (cur.op == OP_ALLOC) begin
        if (found) begin
          bw_en   = 1'b1;
          bw_addr = {sel, blk};
          bw_data = 1'b1;
        end
      end else if (!cur.bad && b_rdata) begin
        bw_en = 1'b1;
        qw_en = 1'b1;
      end
    end
  end

  // Read and write memories
  always_ff @(posedge clk) begin
    if (rd_en) q_rdata <= qmem[q_raddr];
    if (qw_en) qmem[qw_addr] <= qw_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) b_rdata <= bmem[b_raddr];
    if (bw_en) bmem[bw_addr] <= bw_data;
  end

  // Latch request context
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur   <= q_head;
      sel   <= sel_next;
      found <= found_next;
      wrt   <= wrt_next;
      hsave <= hsave_next;
    end
  end

  // Control state, pool pointers, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pend      <= '1;
      clr_pool  <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      for (int p = 0; p < POOLS; p++) begin
        head[p]  <= '0;
        tail[p]  <= '0;
        qfill[p] <= '0;
        wcnt[p]  <= '0;
      end
    end else begin
      state    <= state_next;
      clr_pool <= clr_pool_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == '1) pend[clr_pool] <= 1'b0;
      end else begin
        clr_cnt <= '0;
      end
      if (do_exec) begin
        out_valid <= 1'b1;
        if (cur.op == OP_ALLOC) begin
          if (found) begin
            status        <= ST_OK;
            granted_pool  <= sel;
            granted_index <= blk;
            head[sel]     <= hsave + 1'b1;
            qfill[sel]    <= qfill[sel] - 1'b1;
          end else begin
            status        <= ST_NO_FIT;
            granted_pool  <= '0;
            granted_index <= '0;
          end
        end else begin
          granted_pool  <= '0;
          granted_index <= '0;
          if (cur.bad) begin
            status <= ST_BAD;
          end else if (!b_rdata) begin
            status <= ST_DOUBLE;
          end else begin
            status          <= ST_OK;
            tail[cur.pool]  <= tail[cur.pool] + 1'b1;
            if (qfill[cur.pool] < CW'(BLOCKS)) qfill[cur.pool] <= qfill[cur.pool] + 1'b1;
            if (wcnt[cur.pool] < CW'(BLOCKS)) wcnt[cur.pool] <= wcnt[cur.pool] + 1'b1;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // Reinitialize a pool on count write
      if (cnt_wr.en) begin
        head[cnt_wr.pool]  <= '0;
        tail[cnt_wr.pool]  <= cnt_wr.eff[IW-1:0];
        qfill[cnt_wr.pool] <= cnt_wr.eff;
        wcnt[cnt_wr.pool]  <= '0;
        pend[cnt_wr.pool]  <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/size_class_block_allocator_core.sv */
// Top level of the size class block allocator: config registers, front and back.
`default_nettype none
// Four pools of fixed-size blocks, up to 256 blocks each. An allocate word goes
// to the lowest pool whose block size fits and whose free queue is not empty;
// a free word returns a block to its pool's queue tail. Each word yields one
// result word. The back end first reads the queue store and bitmap
// synchronously, then writes and gives the result, and takes no new word until
// the last is done; a result held by out_stall holds the back end. After
// reset the bitmap is cleared in four passes, one per pool, and each block
// count write starts a pass over that pool; no input word is accepted during
// these passes. Write registers only while idle.
module size_class_block_allocator_core import scba_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire logic [2:0]      wr_index,
  input  wire logic [SW-1:0]   wr_data,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            operation,
  input  wire logic [SW-1:0]   request_size,
  input  wire logic [PW-1:0]   pool_id,
  input  wire logic [IW-1:0]   block_index,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [1:0]           status,
  output logic [PW-1:0]        granted_pool,
  output logic [IW-1:0]        granted_index
);

  logic [SW-1:0] pool_size   [POOLS];
  logic [8:0]    block_count [POOLS];
  logic [CW-1:0] eff [POOLS];
  cnt_wr_t       cnt_wr;
  logic          hold, q_valid, q_pop;
  req_t          q_head;

  // Decode register writes
  always_comb begin
    cnt_wr.en   = 1'b0;
    cnt_wr.pool = wr_index[PW-1:0];
    cnt_wr.eff  = eff_count(wr_data[8:0]);
    if (wr_en) begin
      unique case (wr_index) inside
        REG_COUNT_0, REG_COUNT_1, REG_COUNT_2, REG_COUNT_3: cnt_wr.en = 1'b1;
        default: cnt_wr.en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < POOLS; p++) begin
        pool_size[p]   <= '0;
        block_count[p] <= '0;
      end
    end else if (wr_en) begin
      unique case (wr_index) inside
        REG_SIZE_0, REG_SIZE_1, REG_SIZE_2, REG_SIZE_3:
          pool_size[wr_index[PW-1:0]] <= wr_data;
        REG_COUNT_0, REG_COUNT_1, REG_COUNT_2, REG_COUNT_3:
          block_count[wr_index[PW-1:0]] <= wr_data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int p = 0; p < POOLS; p++) eff[p] = eff_count(block_count[p]);
  end

  scba_front u_front (
    .clk, .rst, .in_valid, .in_stall, .operation, .request_size, .pool_id,
    .block_index, .pool_size, .block_count, .hold, .q_valid, .q_head, .q_pop
  );

  scba_back u_back (
    .clk, .rst, .eff, .cnt_wr, .q_valid, .q_head, .q_pop, .hold, .out_valid,
    .out_stall, .status, .granted_pool, .granted_index
  );

endmodule
`default_nettype wire
